FILE: rtl/linear_probe_hash_table_macros.svh
// Assertion macros shared by the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lpht_pkg.sv
// Sizes, field widths and operation and status codes of the hash table.
package lpht_pkg;

  localparam int BUCKET_COUNT     = 64;
  localparam int SLOTS_PER_BUCKET = 3;

  localparam int BUCKET_W = $clog2(BUCKET_COUNT);
  localparam int SLOT_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 64;
  localparam int LIMIT_W  = 7;
  localparam int CMP_W    = (BUCKET_W > LIMIT_W) ? BUCKET_W : LIMIT_W;

  localparam logic [BUCKET_W:0] PROBE_CAP = (BUCKET_W + 1)'(BUCKET_COUNT / 2 - 1);
  localparam logic [LIMIT_W-1:0] HINT_RESET = LIMIT_W'(12);

  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_PUT    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_PRESENT   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

endpackage

FILE: rtl/linear_probe_hash_table.sv
// Bucketed linear-probing hash table with get, put and remove requests.
// Each key hashes to a home bucket (its low bits) and lives within that bucket's
// probe distance; one bucket row of keys and values is read per cycle from
// single-port memories, with slot occupancy and distance validity in flip-flops,
// so no clearing pass is needed after reset. A request is accepted in S_IDLE, has its
// home probe distance read in S_DIST, probes one bucket at a time in S_SCAN (the
// distance plus one buckets, and for a put that must widen its range one more per
// extra bucket in S_EXT, up to BUCKET_COUNT/2 - 1 in total), and waits in S_DONE
// until the output register is free to take the result. A zero key or an OP_NONE
// request goes from S_IDLE straight to S_DONE. A new request is taken once the
// previous one sits in the output register.
`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lpht_pkg::LIMIT_W-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         req_type_i,
  input  logic [lpht_pkg::KEY_W-1:0]         key_i,
  input  logic [lpht_pkg::VALUE_W-1:0]       value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         status_o,
  output logic [lpht_pkg::VALUE_W-1:0]       value_out_o,
  output logic                               resize_hint_o
);

  localparam int NB = lpht_pkg::BUCKET_COUNT;
  localparam int SL = lpht_pkg::SLOTS_PER_BUCKET;
  localparam int BW = lpht_pkg::BUCKET_W;
  localparam int SW = lpht_pkg::SLOT_W;
  localparam int KW = lpht_pkg::KEY_W;
  localparam int VW = lpht_pkg::VALUE_W;
  localparam int LW = lpht_pkg::LIMIT_W;
  localparam int CW = lpht_pkg::CMP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIST,
    S_SCAN,
    S_EXT,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [1:0]      op_q, op_d;
  logic [KW-1:0]   key_q, key_d;
  logic [VW-1:0]   val_q, val_d;
  logic [BW-1:0]   home_q, home_d;
  logic [BW-1:0]   dist_q, dist_d;
  logic [BW-1:0]   off_q, off_d;
  logic            emp_found_q, emp_found_d;
  logic [BW-1:0]   emp_bucket_q, emp_bucket_d;
  logic [SW-1:0]   emp_slot_q, emp_slot_d;
  logic [2:0]      res_status_q, res_status_d;
  logic [VW-1:0]   res_value_q, res_value_d;
  logic            res_hint_q, res_hint_d;
  logic            out_valid_q;
  logic [2:0]      status_q;
  logic [VW-1:0]   value_out_q;
  logic            hint_q;
  logic [LW-1:0]   limit_q;

  logic [KW-1:0]   key_mem [NB][SL];
  logic [VW-1:0]   val_mem [NB][SL];
  logic [BW-1:0]   dist_mem [NB];
  logic [SL-1:0]   slot_vld_q [NB];
  logic [NB-1:0]   dist_vld_q;

  logic [KW-1:0]   key_row_q [SL];
  logic [VW-1:0]   val_row_q [SL];
  logic [SL-1:0]   vld_row_q;
  logic [BW-1:0]   dist_rd_q;

  logic            rd_en;
  logic [BW-1:0]   rd_bucket;
  logic            dist_rd_en;
  logic            key_we;
  logic [BW-1:0]   wr_bucket;
  logic [SW-1:0]   wr_slot;
  logic            vld_clr;
  logic            dist_we;
  logic            out_load;

  logic [BW-1:0]   cur_bucket;
  logic            hit;
  logic [SW-1:0]   hit_slot;
  logic            emp;
  logic [SW-1:0]   emp_slot;
  logic [BW:0]     off_inc;
  logic            found_now;

  assign cur_bucket = home_q + off_q;
  assign off_inc    = {1'b0, off_q} + (BW + 1)'(1);
  assign found_now  = emp_found_q || emp;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    emp      = 1'b0;
    emp_slot = '0;
    for (int s = SL - 1; s >= 0; s--) begin
      if (vld_row_q[s] && (key_row_q[s] == key_q)) begin
        hit      = 1'b1;
        hit_slot = SW'(s);
      end
      if (!vld_row_q[s]) begin
        emp      = 1'b1;
        emp_slot = SW'(s);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    val_d        = val_q;
    home_d       = home_q;
    dist_d       = dist_q;
    off_d        = off_q;
    emp_found_d  = emp_found_q;
    emp_bucket_d = emp_bucket_q;
    emp_slot_d   = emp_slot_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_hint_d   = res_hint_q;
    rd_en        = 1'b0;
    rd_bucket    = cur_bucket;
    dist_rd_en   = 1'b0;
    key_we       = 1'b0;
    wr_bucket    = cur_bucket;
    wr_slot      = emp_slot;
    vld_clr      = 1'b0;
    dist_we      = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = req_type_i;
          key_d        = key_i;
          val_d        = value_i;
          home_d       = key_i[BW-1:0];
          off_d        = '0;
          emp_found_d  = 1'b0;
          res_status_d = lpht_pkg::ST_OK;
          res_value_d  = '0;
          res_hint_d   = 1'b0;
          if (req_type_i == lpht_pkg::OP_NONE) begin
            res_status_d = lpht_pkg::ST_NOT_FOUND;
            state_d      = S_DONE;
          end else if (key_i == '0) begin
            res_status_d = lpht_pkg::ST_INVALID;
            state_d      = S_DONE;
          end else begin
            dist_rd_en = 1'b1;
            state_d    = S_DIST;
          end
        end
      end
      S_DIST: begin
        dist_d    = dist_vld_q[home_q] ? dist_rd_q : '0;
        rd_en     = 1'b1;
        rd_bucket = home_q;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_DONE;
          if (op_q == lpht_pkg::OP_PUT) begin
            res_status_d = lpht_pkg::ST_PRESENT;
          end else begin
            res_value_d = val_row_q[hit_slot];
            vld_clr     = (op_q == lpht_pkg::OP_REMOVE);
          end
        end else begin
          if (!emp_found_q && emp) begin
            emp_found_d  = 1'b1;
            emp_bucket_d = cur_bucket;
            emp_slot_d   = emp_slot;
          end
          if (off_q == dist_q) begin
            if (op_q != lpht_pkg::OP_PUT) begin
              res_status_d = lpht_pkg::ST_NOT_FOUND;
              state_d      = S_DONE;
            end else if (found_now) begin
              key_we     = 1'b1;
              wr_bucket  = emp_found_q ? emp_bucket_q : cur_bucket;
              wr_slot    = emp_found_q ? emp_slot_q : emp_slot;
              res_hint_d = CW'(dist_q) > CW'(limit_q);
              state_d    = S_DONE;
            end else if (off_inc >= lpht_pkg::PROBE_CAP) begin
              res_status_d = lpht_pkg::ST_FULL;
              state_d      = S_DONE;
            end else begin
              off_d     = off_inc[BW-1:0];
              rd_en     = 1'b1;
              rd_bucket = home_q + off_inc[BW-1:0];
              state_d   = S_EXT;
            end
          end else begin
            off_d     = off_inc[BW-1:0];
            rd_en     = 1'b1;
            rd_bucket = home_q + off_inc[BW-1:0];
          end
        end
      end
      S_EXT: begin
        if (emp) begin
          key_we     = 1'b1;
          dist_we    = 1'b1;
          res_hint_d = CW'(off_q) > CW'(limit_q);
          state_d    = S_DONE;
        end else if (off_inc >= lpht_pkg::PROBE_CAP) begin
          res_status_d = lpht_pkg::ST_FULL;
          state_d      = S_DONE;
        end else begin
          off_d     = off_inc[BW-1:0];
          rd_en     = 1'b1;
          rd_bucket = home_q + off_inc[BW-1:0];
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      status_q     <= lpht_pkg::ST_OK;
      value_out_q  <= '0;
      hint_q       <= 1'b0;
      limit_q      <= lpht_pkg::HINT_RESET;
      emp_found_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      emp_found_q <= emp_found_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        status_q    <= res_status_q;
        value_out_q <= res_value_q;
        hint_q      <= res_hint_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    home_q       <= home_d;
    dist_q       <= dist_d;
    off_q        <= off_d;
    emp_bucket_q <= emp_bucket_d;
    emp_slot_q   <= emp_slot_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_hint_q   <= res_hint_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_bucket][wr_slot] <= key_q;
      val_mem[wr_bucket][wr_slot] <= val_q;
    end
    if (rd_en) begin
      key_row_q <= key_mem[rd_bucket];
      val_row_q <= val_mem[rd_bucket];
      vld_row_q <= slot_vld_q[rd_bucket];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[home_q] <= off_q;
    end
    if (dist_rd_en) begin
      dist_rd_q <= dist_mem[home_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NB; b++) begin
        slot_vld_q[b] <= '0;
      end
      dist_vld_q <= '0;
    end else begin
      if (key_we) begin
        slot_vld_q[wr_bucket][wr_slot] <= 1'b1;
      end
      if (vld_clr) begin
        slot_vld_q[cur_bucket][hit_slot] <= 1'b0;
      end
      if (dist_we) begin
        dist_vld_q[home_q] <= 1'b1;
      end
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign value_out_o   = value_out_q;
  assign resize_hint_o = hint_q;

  `LPHT_ASSERT_NEXT(a_no_early_result, in_valid_i && !in_stall_o, !$rose(out_valid_o), "result appeared one cycle after a request transfer")
  `LPHT_ASSERT_NOW(a_put_write, key_we, (op_q == lpht_pkg::OP_PUT) && (key_q != '0), "slot written outside a put of a nonzero key")
  `LPHT_ASSERT_NOW(a_dist_grow, dist_we, (state_q == S_EXT) && (off_q > dist_q), "probe distance written without growing")
  `LPHT_ASSERT_NOW(a_remove_hit, vld_clr, (op_q == lpht_pkg::OP_REMOVE) && hit, "slot cleared without a matching remove")

endmodule
